// ===== hdl/kil_pkg.sv =====
// Shared types and constants for the keyword/identifier lexer.
// Holds the channel payloads, controller/datapath command and status, and keyword tables.
// No dependencies.
package kil_pkg;

   localparam int NUM_KW      = 10;
   localparam int KW_MAX_LEN  = 6;
   localparam int NUM_SINGLES = 9;

   localparam logic [4:0] KIND_IDENT       = 5'd0;
   localparam logic [4:0] KIND_KW_BASE     = 5'd1;
   localparam logic [4:0] KIND_SINGLE_BASE = 5'd11;

   // keyword text, zero padded; order sets the kind code and the match priority
   localparam logic [7:0] KW_CHAR [NUM_KW][KW_MAX_LEN] = '{
      '{"b", "r", "e", "a", "k", 8'h00},
      '{"c", "h", "a", "r", 8'h00, 8'h00},
      '{"e", "l", "s", "e", 8'h00, 8'h00},
      '{"e", "l", "i", "f", 8'h00, 8'h00},
      '{"f", "l", "o", "a", "t", 8'h00},
      '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
      '{"r", "e", "t", "u", "r", "n"},
      '{"v", "o", "i", "d", 8'h00, 8'h00},
      '{"w", "h", "i", "l", "e", 8'h00}
   };
   localparam logic [2:0] KW_LEN [NUM_KW] = '{
      3'd5, 3'd4, 3'd4, 3'd4, 3'd5, 3'd2, 3'd3, 3'd6, 3'd4, 3'd5
   };
   localparam logic [7:0] SINGLE_CHAR [NUM_SINGLES] = '{
      " ", ";", ",", "{", "}", "(", ")", "[", "]"
   };

   typedef struct packed {
      logic [7:0] source_byte;
      logic       source_end;
   } lex_req_type;

   typedef struct packed {
      logic [4:0] token_kind;
      logic [7:0] token_char;
      logic       token_last;
      logic       token_truncated;
      logic       stream_done;
   } lex_rsp_type;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_KEYWORD,
      MODE_IDENT
   } lex_mode_type;

   typedef enum logic [1:0] {
      SEQ_READY,
      SEQ_DRAIN,
      SEQ_EXTRA
   } seq_state_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_ONE,
      CNT_ZERO
   } cnt_op_type;

   typedef struct packed {
      logic       take;
      logic       mem_wr_cnt;
      logic       mem_wr_head_in;
      logic       mem_wr_head_ff;
      cnt_op_type cnt_op;
      logic       drain;
      logic       drain_after;
      logic [4:0] drain_kind;
      logic       extra;
      logic [4:0] extra_kind;
      logic       emit_drain;
      logic       emit_extra;
      logic       done;
   } lex_cmd_type;

   typedef struct packed {
      logic       letter;
      logic       single_hit;
      logic [4:0] single_kind;
      logic       kw_hit;
      logic [4:0] kw_kind;
      logic       kw_done;
      logic       st_hit;
      logic       load_ok;
      logic       drain_last;
   } lex_status_type;

endpackage

// ===== hdl/kil_datapath.sv =====
// Lexer datapath: character buffer, count and keyword candidate mask, drain
// counter and output register. Uses kil_pkg; driven by kil_ctrl.
module kil_datapath #(
   parameter int MAX_TOKEN_LEN = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  kil_pkg::lex_req_type   req_data,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output kil_pkg::lex_rsp_type   rsp_data,
   input  kil_pkg::lex_cmd_type   cmd,
   output kil_pkg::lex_status_type status
);

   localparam int CW = $clog2(MAX_TOKEN_LEN + 1);
   localparam int IW = $clog2(MAX_TOKEN_LEN);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TOKEN_LEN);
   localparam logic [CW-1:0] KW_LIM  = CW'(kil_pkg::KW_MAX_LEN);

   logic [7:0] mem [MAX_TOKEN_LEN];
   logic [7:0] rd_data_ff;

   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [kil_pkg::NUM_KW-1:0] cand_ff, cand_in, cand_next, st_mask;

   logic [7:0]    c_ff;
   logic [CW-1:0] len_ff, len_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [4:0]    drain_kind_ff;
   logic          trunc_ff, trunc_in;
   logic [4:0]    extra_kind_ff;

   logic          out_valid_ff;
   kil_pkg::lex_rsp_type out_ff;

   logic [7:0]    c;
   logic          wr_en;
   logic [IW-1:0] wr_addr, rd_addr;
   logic [7:0]    wr_data;
   logic [3:0]    kw_k;
   logic [CW-1:0] count_inc;

   assign c         = req_data.source_byte;
   assign count_inc = count_ff + CW'(1);

   // classify the incoming byte
   always_comb begin
      status = '0;
      status.letter = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
      for (int i = 0; i < kil_pkg::NUM_SINGLES; i++) begin
         if (!status.single_hit && c == kil_pkg::SINGLE_CHAR[i]) begin
            status.single_hit  = 1'b1;
            status.single_kind = kil_pkg::KIND_SINGLE_BASE + 5'(i);
         end
      end
      for (int k = 0; k < kil_pkg::NUM_KW; k++) begin
         cand_next[k] = cand_ff[k] && (count_ff < KW_LIM)
                        && (CW'(kil_pkg::KW_LEN[k]) > count_ff)
                        && (kil_pkg::KW_CHAR[k][count_ff[2:0]] == c);
         st_mask[k]   = (kil_pkg::KW_CHAR[k][0] == c);
      end
      kw_k = 4'd0;
      for (int k = kil_pkg::NUM_KW - 1; k >= 0; k--) begin
         if (cand_next[k]) kw_k = 4'(k);
      end
      status.kw_hit     = |cand_next;
      status.kw_kind    = kil_pkg::KIND_KW_BASE + 5'(kw_k);
      status.kw_done    = CW'(kil_pkg::KW_LEN[kw_k]) == count_inc;
      status.st_hit     = |st_mask;
      status.load_ok    = !out_valid_ff || !rsp_stall;
      status.drain_last = ({1'b0, idx_ff} + (CW+1)'(1)) == {1'b0, len_ff};
   end

   // token state update on accept
   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      cand_in  = cand_ff;
      if (cmd.take) begin
         case (cmd.cnt_op)
            kil_pkg::CNT_INC: begin
               if (count_ff < MAX_CNT) count_in = count_inc;
               else ovf_in = 1'b1;
               cand_in = cand_next;
            end
            kil_pkg::CNT_ONE: begin
               count_in = CW'(1);
               ovf_in   = 1'b0;
               cand_in  = st_mask;
            end
            kil_pkg::CNT_ZERO: begin
               count_in = '0;
               ovf_in   = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         cand_ff  <= '0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         cand_ff  <= cand_in;
      end
   end

   // drain length counts the appended byte when the token closes on it
   always_comb begin
      len_in   = count_ff;
      trunc_in = ovf_ff;
      if (cmd.drain_after) begin
         if (count_ff < MAX_CNT) len_in = count_inc;
         else trunc_in = 1'b1;
      end
      idx_in = idx_ff;
      if (cmd.take) idx_in = '0;
      else if (cmd.emit_drain) idx_in = idx_ff + CW'(1);
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.take) begin
         c_ff <= c;
      end
      if (cmd.take && cmd.drain) begin
         len_ff        <= len_in;
         drain_kind_ff <= cmd.drain_kind;
         trunc_ff      <= trunc_in;
      end
      if (cmd.take && cmd.extra) begin
         extra_kind_ff <= cmd.extra_kind;
      end
   end

   // buffer memory: one write port, one registered read port
   always_comb begin
      wr_en   = (cmd.mem_wr_cnt && count_ff < MAX_CNT) || cmd.mem_wr_head_in
                || cmd.mem_wr_head_ff;
      wr_addr = (cmd.mem_wr_head_in || cmd.mem_wr_head_ff) ? '0 : count_ff[IW-1:0];
      wr_data = cmd.mem_wr_head_ff ? c_ff : c;
      rd_addr = (idx_in < MAX_CNT) ? idx_in[IW-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit_drain || cmd.emit_extra) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.emit_drain) begin
         out_ff.token_kind      <= drain_kind_ff;
         out_ff.token_char      <= rd_data_ff;
         out_ff.token_last      <= status.drain_last;
         out_ff.token_truncated <= trunc_ff;
         out_ff.stream_done     <= cmd.done;
      end else if (cmd.emit_extra) begin
         out_ff.token_kind      <= extra_kind_ff;
         out_ff.token_char      <= c_ff;
         out_ff.token_last      <= 1'b1;
         out_ff.token_truncated <= 1'b0;
         out_ff.stream_done     <= cmd.done;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== hdl/kil_ctrl.sv =====
// Lexer controller: lexing mode and the sequencer that drains a finished
// token. Uses kil_pkg; commands kil_datapath.
module kil_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_end,
   output logic                    req_stall,
   input  kil_pkg::lex_status_type status,
   output kil_pkg::lex_cmd_type    cmd
);

   kil_pkg::seq_state_type state_ff, state_in;
   kil_pkg::lex_mode_type  mode_ff, mode_in;
   logic end_ff, end_in;
   logic extra_pend_ff, extra_pend_in;
   logic head_pend_ff, head_pend_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= kil_pkg::SEQ_READY;
         mode_ff       <= kil_pkg::MODE_IDLE;
         end_ff        <= 1'b0;
         extra_pend_ff <= 1'b0;
         head_pend_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         end_ff        <= end_in;
         extra_pend_ff <= extra_pend_in;
         head_pend_ff  <= head_pend_in;
      end
   end

   always_comb begin
      logic do_start;
      state_in      = state_ff;
      mode_in       = mode_ff;
      end_in        = end_ff;
      extra_pend_in = extra_pend_ff;
      head_pend_in  = head_pend_ff;
      cmd           = '0;
      cmd.cnt_op    = kil_pkg::CNT_HOLD;
      req_stall     = 1'b1;
      do_start      = 1'b0;
      case (state_ff)
         kil_pkg::SEQ_READY: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.take = 1'b1;
               end_in   = req_end;
               case (mode_ff)
                  kil_pkg::MODE_KEYWORD: begin
                     if (status.kw_hit) begin
                        cmd.mem_wr_cnt = 1'b1;
                        cmd.cnt_op     = kil_pkg::CNT_INC;
                        if (status.kw_done) begin
                           cmd.drain       = 1'b1;
                           cmd.drain_after = 1'b1;
                           cmd.drain_kind  = status.kw_kind;
                           cmd.cnt_op      = kil_pkg::CNT_ZERO;
                           mode_in         = kil_pkg::MODE_IDLE;
                        end
                     end else if (status.letter) begin
                        cmd.mem_wr_cnt = 1'b1;
                        cmd.cnt_op     = kil_pkg::CNT_INC;
                        mode_in        = kil_pkg::MODE_IDENT;
                     end else begin
                        cmd.drain      = 1'b1;
                        cmd.drain_kind = kil_pkg::KIND_IDENT;
                        do_start       = 1'b1;
                     end
                  end
                  kil_pkg::MODE_IDENT: begin
                     if (status.letter) begin
                        cmd.mem_wr_cnt = 1'b1;
                        cmd.cnt_op     = kil_pkg::CNT_INC;
                     end else begin
                        cmd.drain      = 1'b1;
                        cmd.drain_kind = kil_pkg::KIND_IDENT;
                        do_start       = 1'b1;
                     end
                  end
                  default: do_start = 1'b1;
               endcase
               // last byte closes a token left open by an append
               if (req_end && !do_start && !cmd.drain
                   && (mode_in == kil_pkg::MODE_KEYWORD || mode_in == kil_pkg::MODE_IDENT)) begin
                  cmd.drain       = 1'b1;
                  cmd.drain_after = 1'b1;
                  cmd.drain_kind  = kil_pkg::KIND_IDENT;
                  cmd.cnt_op      = kil_pkg::CNT_ZERO;
                  mode_in         = kil_pkg::MODE_IDLE;
               end
               if (do_start) begin
                  if (status.single_hit) begin
                     cmd.extra      = 1'b1;
                     cmd.extra_kind = status.single_kind;
                     cmd.cnt_op     = kil_pkg::CNT_ZERO;
                     mode_in        = kil_pkg::MODE_IDLE;
                  end else if (req_end) begin
                     cmd.extra      = 1'b1;
                     cmd.extra_kind = kil_pkg::KIND_IDENT;
                     cmd.cnt_op     = kil_pkg::CNT_ZERO;
                     mode_in        = kil_pkg::MODE_IDLE;
                  end else begin
                     cmd.cnt_op = kil_pkg::CNT_ONE;
                     mode_in    = status.st_hit ? kil_pkg::MODE_KEYWORD
                                                : kil_pkg::MODE_IDENT;
                     // defer the head write until the old token has drained
                     if (cmd.drain) head_pend_in = 1'b1;
                     else cmd.mem_wr_head_in = 1'b1;
                  end
               end
               extra_pend_in = cmd.extra;
               if (cmd.drain) state_in = kil_pkg::SEQ_DRAIN;
               else if (cmd.extra) state_in = kil_pkg::SEQ_EXTRA;
            end
         end
         kil_pkg::SEQ_DRAIN: begin
            if (status.load_ok) begin
               cmd.emit_drain = 1'b1;
               cmd.done       = status.drain_last && end_ff && !extra_pend_ff;
               if (status.drain_last) begin
                  cmd.mem_wr_head_ff = head_pend_ff;
                  head_pend_in       = 1'b0;
                  state_in = extra_pend_ff ? kil_pkg::SEQ_EXTRA : kil_pkg::SEQ_READY;
               end
            end
         end
         kil_pkg::SEQ_EXTRA: begin
            if (status.load_ok) begin
               cmd.emit_extra = 1'b1;
               cmd.done       = end_ff;
               extra_pend_in  = 1'b0;
               state_in       = kil_pkg::SEQ_READY;
            end
         end
         default: state_in = kil_pkg::SEQ_READY;
      endcase
   end

endmodule

// ===== hdl/keyword_identifier_lexer_unit.sv =====
// Top level of the keyword/identifier lexer: controller plus datapath.
// Uses kil_pkg, kil_ctrl and kil_datapath.
//
//   port group  direction  payload          accepted when
//   req_*       in         kil_pkg::lex_req_type  req_valid && !req_stall
//   rsp_*       out        kil_pkg::lex_rsp_type  rsp_valid && !rsp_stall
//
// A byte that only extends the open token leaves the sequencer ready. A
// byte that closes a token sends the sequencer to drain each buffered
// character read from the buffer memory, then to emit any single-character
// token; the input is stalled meanwhile. A held rsp_stall pauses the drain.
// Reset clears the mode, count and sequencer; buffer contents are not cleared.
module keyword_identifier_lexer_unit #(
   parameter int MAX_TOKEN_LEN = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  kil_pkg::lex_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output kil_pkg::lex_rsp_type rsp_data
);

   kil_pkg::lex_cmd_type    cmd;
   kil_pkg::lex_status_type status;

   kil_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_end   (req_data.source_end),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   kil_datapath #(
      .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// ===== dv/tb_keyword_identifier_lexer_unit.sv =====
// Self-checking testbench for keyword_identifier_lexer_unit: streams source bytes,
// predicts every token character in a behavioral lexer and compares each result.
// Depends on kil_pkg and the lexer RTL.
module tb_keyword_identifier_lexer_unit;

   localparam int TOKEN_CAP      = 32;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 60;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   kil_pkg::lex_req_type req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   kil_pkg::lex_rsp_type rsp_data;

   int sender_idle_pct = 0;
   int stall_pct       = 0;
   int items_sent      = 0;
   int errors          = 0;
   int quiet_cycles    = 0;

   // lexer state as the predictor sees it
   kil_pkg::lex_mode_type mode_q     = kil_pkg::MODE_IDLE;
   logic [7:0]            held_chars [TOKEN_CAP];
   int                    held_count = 0;
   bit                    held_ovf   = 1'b0;
   kil_pkg::lex_rsp_type  step_chars [$];
   kil_pkg::lex_rsp_type  pending_chars [$];

   keyword_identifier_lexer_unit #(.MAX_TOKEN_LEN(TOKEN_CAP)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   function automatic bit is_letter(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   // keyword whose next character extends the held prefix by c, or -1
   function automatic int keyword_extend(logic [7:0] c);
      bit same;
      for (int k = 0; k < kil_pkg::NUM_KW; k++) begin
         if (int'(kil_pkg::KW_LEN[k]) <= held_count) continue;
         same = 1'b1;
         for (int i = 0; i < held_count; i++)
            if (kil_pkg::KW_CHAR[k][i] != held_chars[i]) same = 1'b0;
         if (same && kil_pkg::KW_CHAR[k][held_count] == c) return k;
      end
      return -1;
   endfunction

   function automatic void emit_char(logic [4:0] kind, logic [7:0] ch, bit last, bit trunc);
      kil_pkg::lex_rsp_type r;
      r.token_kind      = kind;
      r.token_char      = ch;
      r.token_last      = last;
      r.token_truncated = trunc;
      r.stream_done     = 1'b0;
      step_chars.push_back(r);
   endfunction

   function automatic void flush_held(logic [4:0] kind, bit trunc);
      for (int i = 0; i < held_count; i++)
         emit_char(kind, held_chars[i], i + 1 == held_count, trunc);
      held_count = 0;
      held_ovf   = 1'b0;
      mode_q     = kil_pkg::MODE_IDLE;
   endfunction

   function automatic void ident_append(logic [7:0] c);
      if (held_count < TOKEN_CAP) begin
         held_chars[held_count] = c;
         held_count++;
      end else begin
         held_ovf = 1'b1;
      end
   endfunction

   function automatic void start_token(logic [7:0] c);
      int k;
      for (int i = 0; i < kil_pkg::NUM_SINGLES; i++) begin
         if (kil_pkg::SINGLE_CHAR[i] == c) begin
            emit_char(kil_pkg::KIND_SINGLE_BASE + 5'(i), c, 1'b1, 1'b0);
            return;
         end
      end
      held_count    = 0;
      held_ovf      = 1'b0;
      k             = keyword_extend(c);
      held_chars[0] = c;
      held_count    = 1;
      if (k >= 0) mode_q = kil_pkg::MODE_KEYWORD;
      else mode_q = kil_pkg::MODE_IDENT;
   endfunction

   function automatic void lex_predict(kil_pkg::lex_req_type r);
      logic [7:0]           c;
      int                   k;
      kil_pkg::lex_rsp_type tail;
      c = r.source_byte;
      step_chars.delete();
      case (mode_q)
         kil_pkg::MODE_KEYWORD: begin
            k = (held_count < kil_pkg::KW_MAX_LEN) ? keyword_extend(c) : -1;
            if (k >= 0) begin
               held_chars[held_count] = c;
               held_count++;
               if (held_count == int'(kil_pkg::KW_LEN[k]))
                  flush_held(kil_pkg::KIND_KW_BASE + 5'(k), 1'b0);
            end else if (is_letter(c)) begin
               mode_q = kil_pkg::MODE_IDENT;
               ident_append(c);
            end else begin
               flush_held(kil_pkg::KIND_IDENT, held_ovf);
               start_token(c);
            end
         end
         kil_pkg::MODE_IDENT: begin
            if (is_letter(c)) begin
               ident_append(c);
            end else begin
               flush_held(kil_pkg::KIND_IDENT, held_ovf);
               start_token(c);
            end
         end
         default: begin
            mode_q = kil_pkg::MODE_IDLE;
            start_token(c);
         end
      endcase
      if (r.source_end) begin
         if (mode_q != kil_pkg::MODE_IDLE) flush_held(kil_pkg::KIND_IDENT, held_ovf);
         if (step_chars.size() > 0) begin
            tail = step_chars.pop_back();
            tail.stream_done = 1'b1;
            step_chars.push_back(tail);
         end
      end
      foreach (step_chars[i]) pending_chars.push_back(step_chars[i]);
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      errors++;
      $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
   endtask

   task automatic check_char(kil_pkg::lex_rsp_type r);
      kil_pkg::lex_rsp_type want;
      if (pending_chars.size() == 0) begin
         report_mismatch("result with nothing pending, char", int'(r.token_char), 0);
      end else begin
         want = pending_chars.pop_front();
         if (r.token_kind != want.token_kind)
            report_mismatch("token_kind", int'(r.token_kind), int'(want.token_kind));
         if (r.token_char != want.token_char)
            report_mismatch("token_char", int'(r.token_char), int'(want.token_char));
         if (r.token_last != want.token_last)
            report_mismatch("token_last", int'(r.token_last), int'(want.token_last));
         if (r.token_truncated != want.token_truncated)
            report_mismatch("token_truncated", int'(r.token_truncated),
                            int'(want.token_truncated));
         if (r.stream_done != want.stream_done)
            report_mismatch("stream_done", int'(r.stream_done), int'(want.stream_done));
      end
   endtask

   // predict on each accepted item, then check the accepted result of the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) lex_predict(req_data);
         if (rsp_valid && !rsp_stall) check_char(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** keyword_identifier_lexer_unit: FAILED **");
            $finish;
         end
      end
   end

   task automatic send_byte(logic [7:0] b, bit last);
      kil_pkg::lex_req_type req_item;
      req_item.source_byte = b;
      req_item.source_end  = last;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= req_item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(string s, bit end_on_last);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], end_on_last && (i == s.len() - 1));
   endtask

   function automatic logic [7:0] rand_letter();
      logic [7:0] c;
      c = 8'($urandom_range(25));
      return $urandom_range(1) ? "a" + c : "A" + c;
   endfunction

   function automatic logic [7:0] rand_non_letter();
      logic [7:0] c;
      do c = 8'($urandom_range(255)); while (is_letter(c));
      return c;
   endfunction

   function automatic bit rand_end();
      return $urandom_range(39) == 0;
   endfunction

   task automatic send_identifier(int len, bit end_on_last);
      for (int i = 0; i < len; i++)
         send_byte(rand_letter(), end_on_last && (i == len - 1));
   endtask

   // keyword then identifier, failed prefixes either way, every single, the
   // extreme bytes, and a partial keyword cut off by the end of source
   task automatic test_directed();
      send_text("ifx;bre,elsa{}()[]", 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_text(" whi", 1'b1);
   endtask

   task automatic test_long_identifiers();
      send_identifier(TOKEN_CAP, 1'b0);
      send_byte(";", 1'b0);
      send_identifier(TOKEN_CAP + 1, 1'b0);
      send_byte(" ", 1'b0);
      send_identifier(TOKEN_CAP + 8, 1'b1);
   endtask

   task automatic send_random_token();
      int r, k, len;
      r = $urandom_range(99);
      if (r < 30) begin
         k = $urandom_range(kil_pkg::NUM_KW - 1);
         for (int i = 0; i < int'(kil_pkg::KW_LEN[k]); i++)
            send_byte(kil_pkg::KW_CHAR[k][i], rand_end());
      end else if (r < 45) begin
         // keyword prefix broken by a letter or a non-letter
         k   = $urandom_range(kil_pkg::NUM_KW - 1);
         len = $urandom_range(int'(kil_pkg::KW_LEN[k]) - 1, 1);
         for (int i = 0; i < len; i++)
            send_byte(kil_pkg::KW_CHAR[k][i], rand_end());
         send_byte($urandom_range(1) ? rand_letter() : rand_non_letter(), rand_end());
      end else if (r < 65) begin
         len = ($urandom_range(19) == 0) ? $urandom_range(40, 28) : $urandom_range(8, 1);
         send_byte($urandom_range(4) == 0 ? 8'($urandom_range(255)) : rand_letter(),
                   rand_end());
         send_identifier(len - 1, 1'b0);
      end else if (r < 85) begin
         send_byte(kil_pkg::SINGLE_CHAR[$urandom_range(kil_pkg::NUM_SINGLES - 1)],
                   rand_end());
      end else begin
         send_byte(8'($urandom_range(255)), rand_end());
      end
   endtask

   task automatic test_random_tokens(int count);
      int start;
      start = items_sent;
      while (items_sent - start < count) send_random_token();
   endtask

   // hold the input until every pending character has come out
   task automatic test_drain_pause();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_chars.size() != 0) @(negedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      sender_idle_pct = 30;
      stall_pct       = 71;
      test_directed();
      test_random_tokens(80);

      sender_idle_pct = 71;
      stall_pct       = 30;
      test_long_identifiers();
      test_drain_pause();
      test_random_tokens(80);

      sender_idle_pct = 0;
      stall_pct       = 0;
      test_random_tokens(80);

      req_valid <= 1'b0;
      while (pending_chars.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (errors == 0)
         $display("** keyword_identifier_lexer_unit: PASSED **");
      else
         $display("** keyword_identifier_lexer_unit: FAILED **");
      $finish;
   end

endmodule
